// ----- sv/vertex_attribute_layout_packer_assert.svh -----
// Assertion macros shared by the vertex attribute layout packer checkers.
`ifndef VERTEX_ATTRIBUTE_LAYOUT_PACKER_ASSERT_SVH
`define VERTEX_ATTRIBUTE_LAYOUT_PACKER_ASSERT_SVH

// Property checked on every rising clk edge outside of reset.
`define VALP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked on every rising clk edge, reset included.
`define VALP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/valp_pkg.sv -----
// Types and constants shared by the vertex attribute layout packer modules.
package valp_pkg;

  // Width of an attribute offset or a vertex stride.
  localparam int OFFSET_BITS = 11;
  // The running offset holds one more bit so that it can saturate just past range.
  localparam int RUN_W = OFFSET_BITS + 1;
  // Intermediate sums: a padded offset plus an attribute size.
  localparam int SUM_W = OFFSET_BITS + 2;
  localparam int SIZE_W = 7;
  localparam int COUNT_W = 5;
  localparam int ALIGN_W = 4;

  localparam logic [OFFSET_BITS-1:0] OFS_MAX = '1;
  localparam logic [RUN_W-1:0] RUN_LIMIT = {1'b1, {OFFSET_BITS{1'b0}}};
  localparam logic [ALIGN_W-1:0] ALIGN_ONE = ALIGN_W'(1);
  localparam logic [ALIGN_W-1:0] ALIGN_PACKED = ALIGN_W'(4);
  localparam logic [SIZE_W-1:0] SIZE_PACKED = SIZE_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_VEC3 = COUNT_W'(3);

  typedef enum logic [2:0] {
    CT_I8     = 3'd0,
    CT_U8     = 3'd1,
    CT_I16    = 3'd2,
    CT_U16    = 3'd3,
    CT_I32    = 3'd4,
    CT_U32    = 3'd5,
    CT_F32    = 3'd6,
    CT_PACKED = 3'd7
  } comp_type_t;

  // One incoming attribute description.
  typedef struct packed {
    comp_type_t           component_type;
    logic [COUNT_W-1:0]   component_count;
    logic                 last_attribute;
  } attr_t;

  // One placed attribute.
  typedef struct packed {
    logic [OFFSET_BITS-1:0] attribute_offset;
    logic [SIZE_W-1:0]      attribute_size;
    logic [OFFSET_BITS-1:0] vertex_stride;
    logic                   stride_valid;
    logic                   layout_overflow;
  } place_t;

  // Decoded size and alignment passed from the decoder to the layout core.
  typedef struct packed {
    logic [SIZE_W-1:0]  size;
    logic [ALIGN_W-1:0] align;
  } attr_info_t;

endpackage

// ----- sv/valp_attr_decode.sv -----
// Decoder from component type and count to attribute byte size and alignment.
module valp_attr_decode (
  input  valp_pkg::attr_t      attr,
  output valp_pkg::attr_info_t info
);

  logic [1:0]                    unit_shift;
  logic [valp_pkg::ALIGN_W-1:0]  unit_bytes;

  // Component size as a shift: one, two or four bytes.
  always_comb begin
    if (attr.component_type inside {valp_pkg::CT_I8, valp_pkg::CT_U8}) begin
      unit_shift = 2'd0;
    end else if (attr.component_type inside {valp_pkg::CT_I16, valp_pkg::CT_U16}) begin
      unit_shift = 2'd1;
    end else begin
      unit_shift = 2'd2;
    end
    unit_bytes = valp_pkg::ALIGN_ONE << unit_shift;
  end

  // Size is count times component size; three-component byte and short
  // vectors align to four components. Packed 10-10-10-2 is always one word.
  always_comb begin
    if (attr.component_type == valp_pkg::CT_PACKED) begin
      info.size  = valp_pkg::SIZE_PACKED;
      info.align = valp_pkg::ALIGN_PACKED;
    end else begin
      info.size = valp_pkg::SIZE_W'(attr.component_count) << unit_shift;
      if (attr.component_count == valp_pkg::COUNT_VEC3 && unit_shift != 2'd2) begin
        info.align = unit_bytes << 2;
      end else begin
        info.align = unit_bytes;
      end
    end
  end

endmodule

// ----- sv/valp_layout_core.sv -----
// Running offset, head alignment and overflow state with the placement logic.
module valp_layout_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  valp_pkg::attr_info_t info,
  input  logic                 last,
  output valp_pkg::place_t     result
);

  logic [valp_pkg::RUN_W-1:0]       running_offset;
  logic [valp_pkg::RUN_W-1:0]       running_offset_next;
  logic [valp_pkg::ALIGN_W-1:0]     head_alignment;
  logic [valp_pkg::ALIGN_W-1:0]     head_alignment_next;
  logic                             at_format_start;
  logic                             overflow_seen;
  logic                             overflow_seen_next;
  logic [valp_pkg::SUM_W-1:0]       align_mask;
  logic [valp_pkg::SUM_W-1:0]       offs_sum;
  logic [valp_pkg::SUM_W-1:0]       offs_full;
  logic [valp_pkg::SUM_W-1:0]       run_sum;
  logic [valp_pkg::SUM_W-1:0]       head_mask;
  logic [valp_pkg::SUM_W-1:0]       stride_sum;
  logic [valp_pkg::SUM_W-1:0]       stride_full;
  logic                             offs_ovf;
  logic                             stride_ovf;
  logic [valp_pkg::OFFSET_BITS-1:0] offs;
  logic [valp_pkg::OFFSET_BITS-1:0] stride;

  // Pad the running offset up to this attribute's alignment.
  always_comb begin
    align_mask = valp_pkg::SUM_W'(info.align - valp_pkg::ALIGN_ONE);
    offs_sum   = valp_pkg::SUM_W'(running_offset) + align_mask;
    offs_full  = offs_sum & ~align_mask;
    offs_ovf   = !at_format_start &&
                 (offs_full[valp_pkg::SUM_W-1:valp_pkg::OFFSET_BITS] != '0);
    if (at_format_start) begin
      offs = '0;
    end else if (offs_ovf) begin
      offs = valp_pkg::OFS_MAX;
    end else begin
      offs = offs_full[valp_pkg::OFFSET_BITS-1:0];
    end
  end

  // Advance the running offset, saturating just past the offset range.
  always_comb begin
    run_sum = valp_pkg::SUM_W'(offs) + valp_pkg::SUM_W'(info.size);
    if (run_sum > valp_pkg::SUM_W'(valp_pkg::RUN_LIMIT)) begin
      running_offset_next = valp_pkg::RUN_LIMIT;
    end else begin
      running_offset_next = run_sum[valp_pkg::RUN_W-1:0];
    end
  end

  // The first attribute of a format sets the alignment of the whole vertex.
  always_comb begin
    head_alignment_next = at_format_start ? info.align : head_alignment;
    head_mask   = valp_pkg::SUM_W'(head_alignment_next - valp_pkg::ALIGN_ONE);
    stride_sum  = valp_pkg::SUM_W'(running_offset_next) + head_mask;
    stride_full = stride_sum & ~head_mask;
    stride_ovf  = last && (stride_full[valp_pkg::SUM_W-1:valp_pkg::OFFSET_BITS] != '0);
    if (!last) begin
      stride = '0;
    end else if (stride_ovf) begin
      stride = valp_pkg::OFS_MAX;
    end else begin
      stride = stride_full[valp_pkg::OFFSET_BITS-1:0];
    end
    overflow_seen_next = overflow_seen | offs_ovf | stride_ovf;
  end

  // Result of the attribute currently in the input register.
  always_comb begin
    result.attribute_offset = offs;
    result.attribute_size   = info.size;
    result.vertex_stride    = stride;
    result.stride_valid     = last;
    result.layout_overflow  = overflow_seen_next;
  end

  // Layout state moves on once per placed attribute.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_offset  <= '0;
      head_alignment  <= valp_pkg::ALIGN_ONE;
      at_format_start <= 1'b1;
      overflow_seen   <= 1'b0;
    end else if (advance) begin
      running_offset  <= running_offset_next;
      head_alignment  <= head_alignment_next;
      at_format_start <= last;
      overflow_seen   <= overflow_seen_next;
    end
  end

endmodule

// ----- sv/vertex_attribute_layout_packer.sv -----
// Vertex attribute layout packer: input register, placement core and result register.
//
// Usage:
//   The attr channel takes one attribute description per item: component type,
//   component count and a flag that marks the last attribute of a vertex format.
//   The place channel returns one item per attribute: its aligned byte offset,
//   its byte size and, on the last attribute, the padded vertex stride.
//   The overflow flag is sticky across formats and is cleared only by reset.
// Pipeline and throughput:
//   An accepted item is latched in the input register, then placed and latched in
//   the result register once that register is free; its result shows on place
//   from the result register. While place_ready stays high, one item is taken
//   every cycle; the rate is set by the single add-and-mask pass on the running
//   offset, done between the two registers.
// Reset:
//   Synchronous rst empties both registers and starts a new format at offset 0.
// Stalls:
//   While place_ready is low the result waits in the result register and one
//   more item can still enter the input register; attr_ready then drops until
//   the result is taken.
module vertex_attribute_layout_packer (
  input  logic             clk,
  input  logic             rst,
  input  logic             attr_valid,
  output logic             attr_ready,
  input  valp_pkg::attr_t  attr_item,
  output logic             place_valid,
  input  logic             place_ready,
  output valp_pkg::place_t place_item
);

  logic                 held_valid;
  valp_pkg::attr_t      held_attr;
  logic                 advance;
  valp_pkg::attr_info_t info;
  valp_pkg::place_t     result;

  // The held item moves into the result register when that register is free.
  assign advance    = held_valid && (!place_valid || place_ready);
  assign attr_ready = !held_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (attr_ready) begin
      held_valid <= attr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (attr_valid && attr_ready) begin
      held_attr <= attr_item;
    end
  end

  valp_attr_decode u_decode (
    .attr (held_attr),
    .info (info)
  );

  valp_layout_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .info    (info),
    .last    (held_attr.last_attribute),
    .result  (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      place_valid <= 1'b0;
    end else if (advance) begin
      place_valid <= 1'b1;
    end else if (place_ready) begin
      place_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      place_item <= result;
    end
  end

endmodule

// ----- sv/valp_checker.sv -----
// Port-level checker for the vertex attribute layout packer, bound to the top level.
`include "vertex_attribute_layout_packer_assert.svh"

module valp_checker (
  input logic             clk,
  input logic             rst,
  input logic             attr_valid,
  input logic             attr_ready,
  input logic             place_valid,
  input logic             place_ready,
  input valp_pkg::place_t place_item
);

  // Reset leaves no result pending and the input open.
  `VALP_ASSERT_RST(a_reset_idle, rst |=> (!place_valid && attr_ready), "not idle after reset")

  // Only the last attribute of a format carries a stride.
  `VALP_ASSERT(a_stride_zero, (place_valid && !place_item.stride_valid) |-> (place_item.vertex_stride == '0), "stride on inner attribute")

  // Overflow, once reported, is reported on every later item.
  `VALP_ASSERT(a_overflow_sticky, (place_valid && place_ready && place_item.layout_overflow) |=> (!place_valid || place_item.layout_overflow), "overflow flag dropped")

  // The attribute after a format's last one starts the next format at offset zero.
  `VALP_ASSERT(a_format_restart, (place_valid && place_ready && place_item.stride_valid) |=> (!place_valid || place_item.attribute_offset == '0), "new format not at offset zero")

  // With the receiver ready after an item is accepted, place_valid is raised for it.
  `VALP_ASSERT(a_latency, (attr_valid && attr_ready) ##1 place_ready |=> place_valid, "result late")

endmodule

bind vertex_attribute_layout_packer valp_checker u_valp_checker (
  .clk         (clk),
  .rst         (rst),
  .attr_valid  (attr_valid),
  .attr_ready  (attr_ready),
  .place_valid (place_valid),
  .place_ready (place_ready),
  .place_item  (place_item)
);
